// File: sv/fr_pkg.sv
`timescale 1ns / 1ps
// Shared types, result codes and the CRC-32C byte step of the fragment reassembler.
// No dependencies.
package fr_pkg;

  localparam int HDR_LEN = 5;
  localparam int SEQ_W = 8;
  localparam int CRC_W = 32;
  localparam int TOTAL_W = 9;
  localparam int LEN_OUT_W = 13;
  localparam int INDEX_W = 12;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;

  typedef enum logic {
    REQ_FRAG = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_DONE = 2'd1,
    ST_REJ  = 2'd2,
    ST_READ = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_SEQUENCE = 3'd2,
    ERR_CAPACITY = 3'd3,
    ERR_CHECKSUM = 3'd4
  } err_t;

  typedef struct packed {
    status_t               status;
    err_t                  error_code;
    logic [LEN_OUT_W-1:0]  message_length;
  } res_t;

  function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: sv/fr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/fr_core.sv
`timescale 1ns / 1ps
// Reassembly state, header capture, CRC-32C and fragment-end checks.
// Depends on fr_pkg; drives the message buffer write port.
module fr_core #(
  parameter int BUFFER_BYTES     = 4096,
  parameter int FRAG_PAYLOAD_MAX = 239,
  parameter int LINK_VALUE_MAX   = 244,
  parameter int SEQ_LIMIT        = 255
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [7:0]                      data_byte,
  input  logic                            frag_last,
  output logic                            ram_we,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr,
  output logic [7:0]                      ram_wdata,
  output fr_pkg::res_t                    res
);
  import fr_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int ALEN_W = $clog2(BUFFER_BYTES + LINK_VALUE_MAX + 1);
  localparam int BP_W = $clog2(LINK_VALUE_MAX + 2);
  localparam int PAYLOAD_LEN_MAX = FRAG_PAYLOAD_MAX + HDR_LEN;

  logic              active, active_next;
  logic [CRC_W-1:0]  latched_crc, latched_crc_next;
  logic [SEQ_W-1:0]  first_seq, first_seq_next;
  logic [SEQ_W-1:0]  next_seq, next_seq_next;
  logic [TOTAL_W-1:0] fragment_total, fragment_total_next;
  logic [ALEN_W-1:0] assembled_length, assembled_length_next;
  logic [CRC_W-1:0]  running_crc, running_crc_next;
  logic [BP_W-1:0]   byte_position, byte_position_next;
  logic [SEQ_W-1:0]  header_seq, header_seq_next;
  logic [CRC_W-1:0]  header_crc, header_crc_next;

  logic [CRC_W-1:0]   exp_eff;
  logic [SEQ_W-1:0]   first_eff, next_eff;
  logic [TOTAL_W-1:0] total_eff;
  logic               store_byte;

  always_comb begin
    active_next           = active;
    latched_crc_next      = latched_crc;
    first_seq_next        = first_seq;
    next_seq_next         = next_seq;
    fragment_total_next   = fragment_total;
    assembled_length_next = assembled_length;
    running_crc_next      = running_crc;
    byte_position_next    = byte_position;
    header_seq_next       = header_seq;
    header_crc_next       = header_crc;
    res.status            = ST_WAIT;
    res.error_code        = ERR_NONE;
    res.message_length    = '0;
    store_byte            = 1'b0;
    exp_eff               = latched_crc;
    first_eff             = first_seq;
    next_eff              = next_seq;
    total_eff             = fragment_total;

    // absorb the byte
    if (byte_position < BP_W'(LINK_VALUE_MAX)) begin
      if (byte_position == '0) begin
        header_seq_next = data_byte;
      end else if (byte_position < BP_W'(HDR_LEN)) begin
        for (int i = 0; i < 4; i++) begin
          if (byte_position == BP_W'(i + 1)) begin
            header_crc_next[8*i +: 8] = header_crc[8*i +: 8] | data_byte;
          end
        end
      end else begin
        store_byte            = assembled_length < ALEN_W'(BUFFER_BYTES);
        running_crc_next      = crc32c_byte(running_crc, data_byte);
        assembled_length_next = assembled_length + ALEN_W'(1);
      end
    end
    if (byte_position <= BP_W'(LINK_VALUE_MAX)) begin
      byte_position_next = byte_position + BP_W'(1);
    end

    if (frag_last) begin
      if (!active) begin
        exp_eff   = header_crc_next;
        first_eff = header_seq_next;
        next_eff  = header_seq_next;
        total_eff = '0;
      end
      res.status = ST_REJ;
      priority if (byte_position_next < BP_W'(HDR_LEN) ||
                   byte_position_next > BP_W'(LINK_VALUE_MAX)) begin
        res.error_code = ERR_LENGTH;
      end else if (header_seq_next > SEQ_W'(SEQ_LIMIT) ||
                   32'(byte_position_next) > PAYLOAD_LEN_MAX) begin
        res.error_code = ERR_SEQUENCE;
      end else if (header_crc_next != exp_eff || header_seq_next != next_eff) begin
        res.error_code = ERR_SEQUENCE;
      end else if (assembled_length_next > ALEN_W'(BUFFER_BYTES)) begin
        res.error_code = ERR_CAPACITY;
      end else if (header_seq_next != '0) begin
        res.status = ST_WAIT;
      end else if ((total_eff + TOTAL_W'(1)) != ({1'b0, first_eff} + TOTAL_W'(1)) ||
                   ~running_crc_next != exp_eff) begin
        res.error_code = ERR_CHECKSUM;
      end else begin
        res.status         = ST_DONE;
        res.message_length = LEN_OUT_W'(assembled_length_next);
      end

      byte_position_next = '0;
      if (res.status == ST_WAIT) begin
        active_next         = 1'b1;
        latched_crc_next    = exp_eff;
        first_seq_next      = first_eff;
        next_seq_next       = header_seq_next - SEQ_W'(1);
        fragment_total_next = total_eff + TOTAL_W'(1);
        header_seq_next     = '0;
        header_crc_next     = '0;
      end else begin
        // reject or complete: drop all reassembly state
        active_next           = 1'b0;
        latched_crc_next      = '0;
        first_seq_next        = '0;
        next_seq_next         = '0;
        fragment_total_next   = '0;
        assembled_length_next = '0;
        running_crc_next      = CRC_INIT;
        header_seq_next       = '0;
        header_crc_next       = '0;
      end
    end
  end

  assign ram_we    = step && store_byte;
  assign ram_waddr = assembled_length[ADDR_W-1:0];
  assign ram_wdata = data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      latched_crc      <= '0;
      first_seq        <= '0;
      next_seq         <= '0;
      fragment_total   <= '0;
      assembled_length <= '0;
      running_crc      <= CRC_INIT;
      byte_position    <= '0;
      header_seq       <= '0;
      header_crc       <= '0;
    end else if (step) begin
      active           <= active_next;
      latched_crc      <= latched_crc_next;
      first_seq        <= first_seq_next;
      next_seq         <= next_seq_next;
      fragment_total   <= fragment_total_next;
      assembled_length <= assembled_length_next;
      running_crc      <= running_crc_next;
      byte_position    <= byte_position_next;
      header_seq       <= header_seq_next;
      header_crc       <= header_crc_next;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && frag_last && res.status == ST_DONE |=> !active && running_crc == CRC_INIT)
    else $error("reassembly state not cleared after completion");

  a_err_only_on_reject: assert property (@(posedge clk) disable iff (rst)
    step |-> (res.error_code != ERR_NONE) == (frag_last && res.status == ST_REJ))
    else $error("error code does not match rejection");

  a_no_store_past_buffer: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> assembled_length < ALEN_W'(BUFFER_BYTES))
    else $error("buffer write beyond capacity");

endmodule

// File: sv/fragment_reassembler.sv
`timescale 1ns / 1ps
// Top level of the fragment reassembler: input stage, result stage, message buffer.
// Depends on fr_pkg, fr_core and fr_ram.
//
// Usage:
//   s_axis carries one request per transfer. tuser = 0 is a fragment byte
//   (tdata[7:0]), with tlast on the final byte of the fragment. tuser = 1 is
//   a read of message buffer byte tdata[19:8].
//   m_axis returns one result for each fragment end and each read; bytes
//   inside a fragment return nothing. tuser gives the status (waiting,
//   complete, rejected, read data); tdata gives error code, message length
//   and read byte.
//   A request passes the input register, then the result register, before output
//   valid. One request is taken per cycle unless one that makes a result waits
//   on m_axis; the CRC-32C update and buffer write for a byte are done from the input register.
//   Reset clears the reassembly state and both stages; the buffer keeps its
//   contents and is not cleared. A byte that was never written reads as
//   unknown.
//   When m_axis stalls, the result holds and one more request waits in the
//   input stage; bytes that make no result still flow through.
module fragment_reassembler #(
  parameter int BUFFER_BYTES     = 4096,
  parameter int FRAG_PAYLOAD_MAX = 239,
  parameter int LINK_VALUE_MAX   = 244,
  parameter int SEQ_LIMIT        = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], read_index[19:8], zero pad
  input  logic        s_axis_tuser,  // req_type
  input  logic        s_axis_tlast,  // frag_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // error_code[2:0], message_length[15:3], read_data[23:16]
  output logic [1:0]  m_axis_tuser   // status
);
  import fr_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);

  logic               in_valid;
  req_t               in_req;
  logic [7:0]         in_byte;
  logic               in_last;
  logic [INDEX_W-1:0] in_index;

  logic   out_valid;
  res_t   out_res;
  logic   out_in_range;

  logic              produces, advance, out_free, frag_step, rd_en, ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;
  res_t              core_res, res_next;

  assign produces      = (in_req == REQ_READ) || in_last;
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && (!produces || out_free);
  assign s_axis_tready = !in_valid || advance;
  assign frag_step     = advance && (in_req == REQ_FRAG);
  assign rd_en         = advance && (in_req == REQ_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req   <= req_t'(s_axis_tuser);
      in_byte  <= s_axis_tdata[7:0];
      in_last  <= s_axis_tlast;
      in_index <= s_axis_tdata[19:8];
    end
  end

  fr_core #(
    .BUFFER_BYTES    (BUFFER_BYTES),
    .FRAG_PAYLOAD_MAX(FRAG_PAYLOAD_MAX),
    .LINK_VALUE_MAX  (LINK_VALUE_MAX),
    .SEQ_LIMIT       (SEQ_LIMIT)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (frag_step),
    .data_byte(in_byte),
    .frag_last(in_last),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .res      (core_res)
  );

  fr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_buffer (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(ADDR_W'(in_index)),
    .rdata(ram_rdata)
  );

  always_comb begin
    res_next = core_res;
    if (in_req == REQ_READ) begin
      res_next.status         = ST_READ;
      res_next.error_code     = ERR_NONE;
      res_next.message_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produces) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      out_res      <= res_next;
      out_in_range <= 32'(in_index) < BUFFER_BYTES;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {(out_res.status == ST_READ && out_in_range) ? ram_rdata : 8'h00,
                          out_res.message_length, out_res.error_code};

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance && produces |=> m_axis_tvalid)
    else $error("result lost after stage advance");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && rd_en))
    else $error("buffer write and read in the same cycle");

  a_read_only_for_reads: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_READ |-> m_axis_tdata[23:16] == 8'h00)
    else $error("read data on a non-read result");

endmodule

// File: sim/tb_fragment_reassembler.sv
`timescale 1ns / 1ps
// Self-checking testbench for fragment_reassembler: random stream traffic on both sides,
// a scoreboard that predicts every status, error, length and read byte.
// Depends on fr_pkg and fragment_reassembler.
module tb_fragment_reassembler;
  import fr_pkg::*;

  localparam int BUF_BYTES   = 4096;
  localparam int PAYLOAD_MAX = 239;
  localparam int LINK_MAX    = 244;
  localparam int SEQ_MAX     = 255;
  localparam int RANDOM_ITEMS = 1080;

  typedef enum int {
    FLAW_NONE,
    FLAW_HDR_CRC,
    FLAW_SEQ,
    FLAW_PAYLOAD,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_CUT
  } flaw_t;

  typedef struct {
    status_t     status;
    err_t        err;
    logic [12:0] length;
    logic [7:0]  data;
  } outcome_t;

  class frag_scoreboard;
    bit          active;
    logic [31:0] crc_latch;
    logic [7:0]  seq_first;
    logic [7:0]  seq_next;
    int unsigned frag_count;
    int unsigned msg_len;
    logic [31:0] crc_run = CRC_INIT;
    int unsigned pos;
    logic [7:0]  hdr_seq;
    logic [31:0] hdr_crc;
    logic [7:0]  image [BUF_BYTES];
    bit          filled [BUF_BYTES];
    int          filled_at [$];
    outcome_t    pending [$];
    int          faults;
    int          transfers;
    int          n_done;
    int          n_wait;
    int          n_read;
    int          rej_by [5];
    int          longest;

    function new();
      restart();
    endfunction

    function logic [31:0] fold_crc(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
        if (r[0] ^ b[k]) r = (r >> 1) ^ CRC_POLY;
        else r = r >> 1;
      end
      return r;
    endfunction

    function void restart();
      active = 1'b0;
      crc_latch = '0;
      seq_first = '0;
      seq_next = '0;
      frag_count = 0;
      msg_len = 0;
      crc_run = CRC_INIT;
      pos = 0;
      hdr_seq = '0;
      hdr_crc = '0;
    endfunction

    function void post(status_t st, err_t e, logic [12:0] len, logic [7:0] rd);
      outcome_t o;
      o.status = st;
      o.err = e;
      o.length = len;
      o.data = rd;
      pending.push_back(o);
      case (st)
        ST_WAIT: n_wait++;
        ST_DONE: n_done++;
        ST_REJ:  rej_by[e]++;
        default: n_read++;
      endcase
    endfunction

    function void reject(err_t e);
      restart();
      post(ST_REJ, e, '0, '0);
    endfunction

    function void note_transfer(req_t kind, logic [7:0] data, logic last, logic [11:0] idx);
      int unsigned flen;
      logic [7:0] seq;
      transfers++;
      if (kind == REQ_READ) begin
        post(ST_READ, ERR_NONE, '0, image[idx]);
        return;
      end
      if (pos < LINK_MAX) begin
        if (pos == 0) begin
          hdr_seq = data;
        end else if (pos < HDR_LEN) begin
          hdr_crc |= {24'h0, data} << (8 * (pos - 1));
        end else begin
          if (msg_len < BUF_BYTES) begin
            image[msg_len] = data;
            if (!filled[msg_len]) begin
              filled[msg_len] = 1'b1;
              filled_at.push_back(msg_len);
            end
          end
          crc_run = fold_crc(crc_run, data);
          msg_len++;
        end
      end
      if (pos <= LINK_MAX) pos++;
      if (!last) return;
      flen = pos;
      pos = 0;
      seq = hdr_seq;
      if (flen < HDR_LEN || flen > LINK_MAX) begin
        reject(ERR_LENGTH);
      end else if (seq > SEQ_MAX || flen - HDR_LEN > PAYLOAD_MAX) begin
        reject(ERR_SEQUENCE);
      end else begin
        if (!active) begin
          active = 1'b1;
          crc_latch = hdr_crc;
          seq_first = seq;
          seq_next = seq;
          frag_count = 0;
        end
        if (hdr_crc != crc_latch || seq != seq_next) begin
          reject(ERR_SEQUENCE);
        end else if (msg_len > BUF_BYTES) begin
          reject(ERR_CAPACITY);
        end else begin
          frag_count++;
          hdr_seq = '0;
          hdr_crc = '0;
          if (seq != 0) begin
            seq_next = seq - 8'd1;
            post(ST_WAIT, ERR_NONE, '0, '0);
          end else if (frag_count != seq_first + 1 || ~crc_run != crc_latch) begin
            reject(ERR_CHECKSUM);
          end else begin
            if (msg_len > longest) longest = msg_len;
            post(ST_DONE, ERR_NONE, 13'(msg_len), '0);
            restart();
          end
        end
      end
    endfunction

    function void check_outcome(logic [1:0] st, logic [2:0] e, logic [12:0] len,
                                logic [7:0] rd);
      outcome_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: status %0d", st);
        faults++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        faults++;
      end
      if (e !== want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, e);
        faults++;
      end
      if (len !== want.length) begin
        $error("message_length: expected %0d, got %0d", want.length, len);
        faults++;
      end
      if (rd !== want.data) begin
        $error("read_data: expected %0h, got %0h", want.data, rd);
        faults++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  frag_scoreboard sb = new;
  int sent;
  int read_mix;
  bit calm_in;

  fragment_reassembler u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int idle_len(input bit calm, input int longest_gap);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, longest_gap);
  endfunction

  function automatic int payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 16);
    if (r < 95) return $urandom_range(17, 80);
    return $urandom_range(PAYLOAD_MAX - 39, PAYLOAD_MAX);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_outcome(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[15:3],
                       m_axis_tdata[23:16]);
  end

  // result side: ready bursts broken by stalls, some stretches never stall
  initial begin
    int span;
    bit calm;
    @(posedge clk);
    forever begin
      calm = ($urandom_range(0, 7) == 0);
      span = $urandom_range(1, 24);
      m_axis_tready <= 1'b1;
      repeat (span) @(posedge clk);
      span = idle_len(calm, 40);
      if (span > 0) begin
        m_axis_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  task automatic send_item(input req_t kind, input logic [7:0] data, input logic last,
                           input logic [11:0] idx);
    int gap;
    gap = idle_len(calm_in, 30);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, idx, data};
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_transfer(kind, data, last, idx);
    sent++;
  endtask

  // only entries already written are ever read
  task automatic send_read(input int want);
    logic [11:0] idx;
    if (sb.filled_at.size() == 0) return;
    if (want >= 0 && want < BUF_BYTES && sb.filled[want]) idx = 12'(want);
    else idx = 12'(sb.filled_at[$urandom_range(0, sb.filled_at.size() - 1)]);
    send_item(REQ_READ, 8'($urandom), 1'($urandom), idx);
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 99) < read_mix) send_read(-1);
      send_item(REQ_FRAG, bytes[i], i == bytes.size() - 1, 12'($urandom));
    end
  endtask

  task automatic send_message(input int frags, input flaw_t flaw, input int total);
    logic [7:0]  body [$];
    logic [7:0]  frag [$];
    int          sizes [$];
    logic [31:0] acc;
    logic [7:0]  b;
    int          n, j, at, bad_at, left, target;
    acc = CRC_INIT;
    if (total > 0) begin
      left = total;
      while (left > 0) begin
        sizes.push_back(left > PAYLOAD_MAX ? PAYLOAD_MAX : left);
        left -= sizes[$];
      end
      frags = sizes.size();
    end else begin
      for (n = 0; n < frags; n++) sizes.push_back(payload_len());
    end
    for (n = 0; n < frags; n++) begin
      for (j = 0; j < sizes[n]; j++) begin
        b = 8'($urandom);
        body.push_back(b);
        acc = sb.fold_crc(acc, b);
      end
    end
    acc = ~acc;
    bad_at = (frags > 8) ? $urandom_range(0, 3) : $urandom_range(0, frags - 1);
    at = 0;
    for (n = 0; n < frags; n++) begin
      frag = {};
      frag.push_back(8'(frags - 1 - n));
      for (j = 0; j < 4; j++) frag.push_back(acc[8*j +: 8]);
      for (j = 0; j < sizes[n]; j++) frag.push_back(body[at + j]);
      at += sizes[n];
      if (n == bad_at) begin
        case (flaw)
          FLAW_CUT: return;
          FLAW_HDR_CRC: frag[$urandom_range(1, 4)] ^= 8'(1 << $urandom_range(0, 7));
          FLAW_SEQ: frag[0] = frag[0] + 8'($urandom_range(1, 3));
          FLAW_PAYLOAD: frag[frag.size() - 1] ^= 8'(1 << $urandom_range(0, 7));
          FLAW_SHORT: begin
            target = $urandom_range(1, 4);
            while (frag.size() > target) void'(frag.pop_back());
          end
          FLAW_LONG: begin
            target = LINK_MAX + $urandom_range(1, 12);
            while (frag.size() < target) frag.push_back(8'($urandom));
          end
          default: ;
        endcase
      end
      send_bytes(frag);
    end
  endtask

  task automatic send_noise();
    logic [7:0] frag [$];
    int n;
    n = $urandom_range(1, 12);
    repeat (n) frag.push_back(8'($urandom));
    send_bytes(frag);
  endtask

  initial begin
    int start, r, frags;
    flaw_t flaw;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, short fragment, extreme bytes, top sequence, bad checksum
    read_mix = 0;
    calm_in = 1'b0;
    send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_bytes('{8'hFF, 8'h00});
    send_message(1, FLAW_NONE, 2);
    send_read(0);
    send_read(1);
    send_bytes('{8'hFF, 8'h78, 8'h56, 8'h34, 8'h12, 8'hA5});
    send_bytes('{8'h00, 8'h78, 8'h56, 8'h34, 8'h12});
    send_bytes('{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});

    // random: mostly well-formed messages, some broken, some noise
    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      calm_in = ($urandom_range(0, 5) == 0);
      read_mix = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_noise();
      end else if (r < 16) begin
        repeat ($urandom_range(1, 4)) send_read(-1);
      end else begin
        r = $urandom_range(0, 99);
        flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE
                                             : flaw_t'($urandom_range(FLAW_HDR_CRC, FLAW_CUT));
        if (r < 55) begin
          frags = $urandom_range(1, 3);
        end else if (r < 88) begin
          frags = $urandom_range(4, 8);
        end else begin
          frags = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(9, 255);
          flaw = FLAW_CUT;
        end
        send_message(frags, flaw, 0);
      end
    end

    // close any open message, then read back stored bytes
    read_mix = 0;
    calm_in = 1'b0;
    send_bytes('{8'h00});
    send_read(0);
    repeat (40) send_read(-1);

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d transfers: %0d complete (largest %0d bytes), %0d waiting, %0d reads",
             sb.transfers, sb.n_done, sb.longest, sb.n_wait, sb.n_read);
    $display("rejections: length %0d, sequence %0d, capacity %0d, checksum %0d",
             sb.rej_by[ERR_LENGTH], sb.rej_by[ERR_SEQUENCE], sb.rej_by[ERR_CAPACITY],
             sb.rej_by[ERR_CHECKSUM]);
    if (sb.faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
